[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every enabled clock edge
`define SPP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition in one cycle requires a consequence in the next
`define SPP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/spp_pkg.sv]
// ----------------------------------------------------------------------------
// spp_pkg
// types, codes and constants of the signature packet parser
// ----------------------------------------------------------------------------
`default_nettype none

package spp_pkg;

	// default limit on signature body bytes
	localparam int MAX_SIG_BYTES_DEF = 512;

	// tag byte fields
	localparam logic [3:0] TAG_SIGNATURE = 4'd2;
	localparam logic [1:0] LEN_TYPE_ONE = 2'd0;
	localparam logic [1:0] LEN_TYPE_TWO = 2'd1;
	localparam logic [1:0] LEN_TYPE_INDET = 2'd3;

	// fixed header values
	localparam logic [7:0] SIG_VERSION = 8'd4;
	localparam logic [7:0] SIG_TYPE_BINARY = 8'd0;

	// subpacket constants
	localparam logic [7:0] SUBLEN_LIMIT = 8'd192;
	localparam logic [7:0] ISSUER_TYPE = 8'd16;
	localparam logic [7:0] ISSUER_SUBLEN = 8'd9;

	// result kinds
	typedef enum logic [1:0] {
		KIND_HASHED = 2'd0,
		KIND_SIG    = 2'd1,
		KIND_REPORT = 2'd2
	} kind_t;

	// error codes
	typedef enum logic [3:0] {
		ERR_OK            = 4'd0,
		ERR_NOT_PACKET    = 4'd1,
		ERR_NEW_FORMAT    = 4'd2,
		ERR_INDETERMINATE = 4'd3,
		ERR_NOT_SIG       = 4'd4,
		ERR_VERSION       = 4'd5,
		ERR_SIGTYPE       = 4'd6,
		ERR_LONG_SUBLEN   = 4'd7,
		ERR_ISSUER_LEN    = 4'd8,
		ERR_OVERRUN       = 4'd9,
		ERR_SIG_TOO_LONG  = 4'd10
	} err_t;

	// parse phases
	typedef enum logic [4:0] {
		PH_IDLE     = 5'd0,
		PH_LEN      = 5'd1,
		PH_VER      = 5'd2,
		PH_STYPE    = 5'd3,
		PH_PALGO    = 5'd4,
		PH_HALGO    = 5'd5,
		PH_HLEN_HI  = 5'd6,
		PH_HLEN_LO  = 5'd7,
		PH_HAREA    = 5'd8,
		PH_ULEN_HI  = 5'd9,
		PH_ULEN_LO  = 5'd10,
		PH_SUB_LEN  = 5'd11,
		PH_SUB_TYPE = 5'd12,
		PH_SUB_BODY = 5'd13,
		PH_HL_HI    = 5'd14,
		PH_HL_LO    = 5'd15,
		PH_SB_HI    = 5'd16,
		PH_SB_LO    = 5'd17,
		PH_SIG      = 5'd18
	} phase_t;

	// one raw input byte
	typedef struct packed {
		logic [7:0] data_byte;
		logic       packet_start;
	} in_item_t;

	// one result item
	typedef struct packed {
		logic [1:0]  item_kind;
		logic [7:0]  out_byte;
		logic [16:0] hashed_count;
		logic [7:0]  hash_algo;
		logic [63:0] issuer_id;
		logic [15:0] hash_left;
		logic [15:0] sig_bits;
		logic [3:0]  error_code;
		logic        final_res;
	} res_t;

endpackage

`default_nettype wire

[design/spp_stream_if.sv]
// ----------------------------------------------------------------------------
// spp stream interfaces
// valid/ready channels for raw packet bytes and for parsed result items
// ----------------------------------------------------------------------------
`default_nettype none

// raw byte channel
interface spp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       packet_start;

	modport source (output valid, output data_byte, output packet_start, input ready);
	modport sink (input valid, input data_byte, input packet_start, output ready);
endinterface

// result channel
interface spp_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  item_kind;
	logic [7:0]  out_byte;
	logic [16:0] hashed_count;
	logic [7:0]  hash_algo;
	logic [63:0] issuer_id;
	logic [15:0] hash_left;
	logic [15:0] sig_bits;
	logic [3:0]  error_code;
	logic        final_res;

	modport source (
		output valid, output item_kind, output out_byte, output hashed_count,
		output hash_algo, output issuer_id, output hash_left, output sig_bits,
		output error_code, output final_res, input ready
	);
	modport sink (
		input valid, input item_kind, input out_byte, input hashed_count,
		input hash_algo, input issuer_id, input hash_left, input sig_bits,
		input error_code, input final_res, output ready
	);
endinterface

`default_nettype wire

[design/signature_packet_parser_unit.sv]
// ----------------------------------------------------------------------------
// signature_packet_parser_unit
// old-format version 4 signature packet parser, one raw byte per transfer
//
//   channel  role   payload
//   raw      sink   data_byte, packet_start
//   parsed   source item_kind, out_byte, hashed_count, hash_algo, issuer_id,
//                   hash_left, sig_bits, error_code, final_res
//
// one raw byte per cycle unless output stalls; each byte gives zero or one result
// a byte passes the input register, then phase logic into the result register
// a byte that gives no result moves on even while a result waits in the output
// a byte that gives a result waits only while the result register is full and stalled
// reset clears the phase machine and every captured field at once
// ----------------------------------------------------------------------------
`default_nettype none

module signature_packet_parser_unit #(
	parameter int MAX_SIG_BYTES = spp_pkg::MAX_SIG_BYTES_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	spp_in_if.sink    raw,
	spp_out_if.source parsed
);

	logic              valid_s1;
	spp_pkg::in_item_t item_s1;
	logic              consume;
	logic              out_free;
	logic              res_valid;
	spp_pkg::res_t     res;

	// input register
	spp_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.raw      (raw),
		.consume  (consume),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	// phase machine and field capture
	spp_parse_core #(
		.MAX_SIG_BYTES (MAX_SIG_BYTES)
	) u_parse_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.out_free  (out_free),
		.consume   (consume),
		.res_valid (res_valid),
		.res       (res)
	);

	// result register
	spp_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (res_valid),
		.res      (res),
		.out_free (out_free),
		.parsed   (parsed)
	);

endmodule

`default_nettype wire

[design/spp_in_stage.sv]
// ----------------------------------------------------------------------------
// spp_in_stage
// input register: holds one raw byte until the parse core takes it
// ----------------------------------------------------------------------------
`default_nettype none

module spp_in_stage (
	input  wire logic              clk,
	input  wire logic              arst_n,
	spp_in_if.sink                 raw,
	input  wire logic              consume,
	output logic                   valid_s1,
	output spp_pkg::in_item_t      item_s1
);

	logic take;

	// a new byte may enter when the stage is empty or drains this cycle
	assign raw.ready = !valid_s1 || consume;
	assign take = raw.valid && raw.ready;

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.data_byte <= raw.data_byte;
			item_s1.packet_start <= raw.packet_start;
		end
	end

endmodule

`default_nettype wire

[design/spp_parse_core.sv]
// ----------------------------------------------------------------------------
// spp_parse_core
// phase machine and field registers; decides one byte per transfer
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module spp_parse_core #(
	parameter int MAX_SIG_BYTES = spp_pkg::MAX_SIG_BYTES_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              valid_s1,
	input  wire spp_pkg::in_item_t item_s1,
	input  wire logic              out_free,
	output logic                   consume,
	output logic                   res_valid,
	output spp_pkg::res_t          res
);

	// signature byte counter width and the byte count of a 16-bit bit count
	localparam int SRW = (MAX_SIG_BYTES > 1) ? $clog2(MAX_SIG_BYTES + 1) : 1;
	localparam int NBW = 14;
	localparam logic [NBW-1:0] MAX_N = NBW'(MAX_SIG_BYTES);

	spp_pkg::phase_t phase_q, phase_d;
	logic [16:0]     fcnt_q, fcnt_d;
	logic [15:0]     hrem_q, hrem_d;
	logic [15:0]     urem_q, urem_d;
	logic [7:0]      srem_q, srem_d;
	logic            issuer_flag_q, issuer_flag_d;
	logic [63:0]     issuer_q, issuer_d;
	logic [7:0]      algo_q, algo_d;
	logic [15:0]     hl_q, hl_d;
	logic [15:0]     sb_q, sb_d;
	logic [SRW-1:0]  sigrem_q, sigrem_d;

	logic            emit;
	logic [1:0]      kind;
	logic [3:0]      err;
	logic            fin;
	logic [7:0]      b;
	logic [15:0]     urem_m1;
	logic [NBW-1:0]  nbytes;
	logic [16:0]     sb_round;

	assign b = item_s1.data_byte;
	assign urem_m1 = urem_q - 16'd1;
	assign sb_round = {1'b0, sb_q[15:8], b} + 17'd7;
	assign nbytes = sb_round[16:3];

	// next state and result for the byte held in the input stage
	always_comb begin
		phase_d = phase_q;
		fcnt_d = fcnt_q;
		hrem_d = hrem_q;
		urem_d = urem_q;
		srem_d = srem_q;
		issuer_flag_d = issuer_flag_q;
		issuer_d = issuer_q;
		algo_d = algo_q;
		hl_d = hl_q;
		sb_d = sb_q;
		sigrem_d = sigrem_q;
		emit = 1'b0;
		kind = spp_pkg::KIND_HASHED;
		err = spp_pkg::ERR_OK;
		fin = 1'b0;
		if (item_s1.packet_start) begin
			// tag byte: restart with everything cleared
			phase_d = spp_pkg::PH_IDLE;
			fcnt_d = '0;
			hrem_d = '0;
			urem_d = '0;
			srem_d = '0;
			issuer_flag_d = 1'b0;
			issuer_d = '0;
			algo_d = '0;
			hl_d = '0;
			sb_d = '0;
			sigrem_d = '0;
			if (!b[7]) begin
				emit = 1'b1; kind = spp_pkg::KIND_REPORT; fin = 1'b1;
				err = spp_pkg::ERR_NOT_PACKET;
			end else if (b[6]) begin
				emit = 1'b1; kind = spp_pkg::KIND_REPORT; fin = 1'b1;
				err = spp_pkg::ERR_NEW_FORMAT;
			end else if (b[1:0] == spp_pkg::LEN_TYPE_INDET) begin
				emit = 1'b1; kind = spp_pkg::KIND_REPORT; fin = 1'b1;
				err = spp_pkg::ERR_INDETERMINATE;
			end else if (b[5:2] != spp_pkg::TAG_SIGNATURE) begin
				emit = 1'b1; kind = spp_pkg::KIND_REPORT; fin = 1'b1;
				err = spp_pkg::ERR_NOT_SIG;
			end else begin
				if (b[1:0] == spp_pkg::LEN_TYPE_ONE) begin
					srem_d = 8'd1;
				end else if (b[1:0] == spp_pkg::LEN_TYPE_TWO) begin
					srem_d = 8'd2;
				end else begin
					srem_d = 8'd4;
				end
				phase_d = spp_pkg::PH_LEN;
			end
		end else begin
			unique case (phase_q)
				spp_pkg::PH_LEN: begin
					// skip the length bytes
					srem_d = srem_q - 8'd1;
					if (srem_d == 8'd0) begin
						phase_d = spp_pkg::PH_VER;
					end
				end
				spp_pkg::PH_VER: begin
					emit = 1'b1;
					if (b != spp_pkg::SIG_VERSION) begin
						phase_d = spp_pkg::PH_IDLE;
						kind = spp_pkg::KIND_REPORT; fin = 1'b1;
						err = spp_pkg::ERR_VERSION;
					end else begin
						phase_d = spp_pkg::PH_STYPE;
						fcnt_d = fcnt_q + 17'd1;
					end
				end
				spp_pkg::PH_STYPE: begin
					emit = 1'b1;
					if (b != spp_pkg::SIG_TYPE_BINARY) begin
						phase_d = spp_pkg::PH_IDLE;
						kind = spp_pkg::KIND_REPORT; fin = 1'b1;
						err = spp_pkg::ERR_SIGTYPE;
					end else begin
						phase_d = spp_pkg::PH_PALGO;
						fcnt_d = fcnt_q + 17'd1;
					end
				end
				spp_pkg::PH_PALGO: begin
					emit = 1'b1;
					fcnt_d = fcnt_q + 17'd1;
					phase_d = spp_pkg::PH_HALGO;
				end
				spp_pkg::PH_HALGO: begin
					emit = 1'b1;
					fcnt_d = fcnt_q + 17'd1;
					algo_d = b;
					phase_d = spp_pkg::PH_HLEN_HI;
				end
				spp_pkg::PH_HLEN_HI: begin
					emit = 1'b1;
					fcnt_d = fcnt_q + 17'd1;
					hrem_d = {b, 8'h00};
					phase_d = spp_pkg::PH_HLEN_LO;
				end
				spp_pkg::PH_HLEN_LO: begin
					emit = 1'b1;
					fcnt_d = fcnt_q + 17'd1;
					hrem_d = {hrem_q[15:8], b};
					phase_d = (hrem_d == 16'd0) ? spp_pkg::PH_ULEN_HI : spp_pkg::PH_HAREA;
				end
				spp_pkg::PH_HAREA: begin
					// hashed subpacket area passes straight through
					emit = 1'b1;
					fcnt_d = fcnt_q + 17'd1;
					hrem_d = hrem_q - 16'd1;
					if (hrem_d == 16'd0) begin
						phase_d = spp_pkg::PH_ULEN_HI;
					end
				end
				spp_pkg::PH_ULEN_HI: begin
					urem_d = {b, 8'h00};
					phase_d = spp_pkg::PH_ULEN_LO;
				end
				spp_pkg::PH_ULEN_LO: begin
					urem_d = {urem_q[15:8], b};
					phase_d = (urem_d == 16'd0) ? spp_pkg::PH_HL_HI : spp_pkg::PH_SUB_LEN;
				end
				spp_pkg::PH_SUB_LEN: begin
					// subpacket length byte, checked against the length limit and the area left
					if (b >= spp_pkg::SUBLEN_LIMIT) begin
						emit = 1'b1; kind = spp_pkg::KIND_REPORT; fin = 1'b1;
						err = spp_pkg::ERR_LONG_SUBLEN;
						phase_d = spp_pkg::PH_IDLE;
					end else if ({8'h00, b} > urem_m1) begin
						emit = 1'b1; kind = spp_pkg::KIND_REPORT; fin = 1'b1;
						err = spp_pkg::ERR_OVERRUN;
						phase_d = spp_pkg::PH_IDLE;
					end else begin
						urem_d = urem_m1;
						srem_d = b;
						if (b == 8'd0) begin
							phase_d = (urem_m1 == 16'd0) ? spp_pkg::PH_HL_HI
								: spp_pkg::PH_SUB_LEN;
						end else begin
							phase_d = spp_pkg::PH_SUB_TYPE;
						end
					end
				end
				spp_pkg::PH_SUB_TYPE: begin
					if ((b == spp_pkg::ISSUER_TYPE) && (srem_q != spp_pkg::ISSUER_SUBLEN)) begin
						emit = 1'b1; kind = spp_pkg::KIND_REPORT; fin = 1'b1;
						err = spp_pkg::ERR_ISSUER_LEN;
						phase_d = spp_pkg::PH_IDLE;
					end else begin
						issuer_flag_d = (b == spp_pkg::ISSUER_TYPE);
						urem_d = urem_m1;
						srem_d = srem_q - 8'd1;
						if (srem_d == 8'd0) begin
							phase_d = (urem_d == 16'd0) ? spp_pkg::PH_HL_HI
								: spp_pkg::PH_SUB_LEN;
						end else begin
							phase_d = spp_pkg::PH_SUB_BODY;
						end
					end
				end
				spp_pkg::PH_SUB_BODY: begin
					// issuer bytes shift in most significant first
					if (issuer_flag_q) begin
						issuer_d = {issuer_q[55:0], b};
					end
					urem_d = urem_m1;
					srem_d = srem_q - 8'd1;
					if (srem_d == 8'd0) begin
						phase_d = (urem_d == 16'd0) ? spp_pkg::PH_HL_HI : spp_pkg::PH_SUB_LEN;
					end
				end
				spp_pkg::PH_HL_HI: begin
					hl_d = {b, 8'h00};
					phase_d = spp_pkg::PH_HL_LO;
				end
				spp_pkg::PH_HL_LO: begin
					hl_d = {hl_q[15:8], b};
					phase_d = spp_pkg::PH_SB_HI;
				end
				spp_pkg::PH_SB_HI: begin
					sb_d = {b, 8'h00};
					phase_d = spp_pkg::PH_SB_LO;
				end
				spp_pkg::PH_SB_LO: begin
					// bit count rounded up to whole bytes
					sb_d = {sb_q[15:8], b};
					if (nbytes > MAX_N) begin
						emit = 1'b1; kind = spp_pkg::KIND_REPORT; fin = 1'b1;
						err = spp_pkg::ERR_SIG_TOO_LONG;
						phase_d = spp_pkg::PH_IDLE;
					end else if (nbytes == '0) begin
						emit = 1'b1; kind = spp_pkg::KIND_REPORT; fin = 1'b1;
						phase_d = spp_pkg::PH_IDLE;
					end else begin
						sigrem_d = nbytes[SRW-1:0];
						phase_d = spp_pkg::PH_SIG;
					end
				end
				spp_pkg::PH_SIG: begin
					emit = 1'b1;
					kind = spp_pkg::KIND_SIG;
					sigrem_d = sigrem_q - SRW'(1);
					if (sigrem_d == '0) begin
						fin = 1'b1;
						phase_d = spp_pkg::PH_IDLE;
					end
				end
				default: begin
					phase_d = spp_pkg::PH_IDLE;
				end
			endcase
		end
	end

	// a byte with no result never waits on the output side
	assign consume = valid_s1 && (!emit || out_free);
	assign res_valid = valid_s1 && emit && out_free;

	// result fields show the values after this byte
	always_comb begin
		res.item_kind = kind;
		res.out_byte = b;
		res.hashed_count = fcnt_d;
		res.hash_algo = algo_d;
		res.issuer_id = issuer_d;
		res.hash_left = hl_d;
		res.sig_bits = sb_d;
		res.error_code = err;
		res.final_res = fin;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= spp_pkg::PH_IDLE;
			fcnt_q <= '0;
			hrem_q <= '0;
			urem_q <= '0;
			srem_q <= '0;
			issuer_flag_q <= 1'b0;
			issuer_q <= '0;
			algo_q <= '0;
			hl_q <= '0;
			sb_q <= '0;
			sigrem_q <= '0;
		end else if (consume) begin
			phase_q <= phase_d;
			fcnt_q <= fcnt_d;
			hrem_q <= hrem_d;
			urem_q <= urem_d;
			srem_q <= srem_d;
			issuer_flag_q <= issuer_flag_d;
			issuer_q <= issuer_d;
			algo_q <= algo_d;
			hl_q <= hl_d;
			sb_q <= sb_d;
			sigrem_q <= sigrem_d;
		end
	end

	// checks
	`SPP_ASSERT_NEXT(a_final_to_idle, res_valid && res.final_res, phase_q == spp_pkg::PH_IDLE, "last item of a packet did not return to idle")
	`SPP_ASSERT(a_sig_count_range, (phase_q == spp_pkg::PH_SIG) |-> ((sigrem_q != '0) && (32'(sigrem_q) <= MAX_SIG_BYTES)), "signature byte counter out of range")
	`SPP_ASSERT(a_report_is_final, (res_valid && (res.item_kind == spp_pkg::KIND_REPORT)) |-> res.final_res, "report without final flag")

endmodule

`default_nettype wire

[design/spp_out_reg.sv]
// ----------------------------------------------------------------------------
// spp_out_reg
// result register: holds one result item until the sink takes it
// ----------------------------------------------------------------------------
`default_nettype none

module spp_out_reg (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          load,
	input  wire spp_pkg::res_t res,
	output logic               out_free,
	spp_out_if.source          parsed
);

	logic          valid_q;
	spp_pkg::res_t res_q;

	// register can be loaded when empty or emptied this cycle
	assign out_free = !valid_q || parsed.ready;

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (parsed.ready) begin
			valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	// drive the channel
	assign parsed.valid = valid_q;
	assign parsed.item_kind = res_q.item_kind;
	assign parsed.out_byte = res_q.out_byte;
	assign parsed.hashed_count = res_q.hashed_count;
	assign parsed.hash_algo = res_q.hash_algo;
	assign parsed.issuer_id = res_q.issuer_id;
	assign parsed.hash_left = res_q.hash_left;
	assign parsed.sig_bits = res_q.sig_bits;
	assign parsed.error_code = res_q.error_code;
	assign parsed.final_res = res_q.final_res;

endmodule

`default_nettype wire
